// File: rtl/core/mts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants of the minimum-tracking stack: request and
// result payloads, stack entry layout, operation and register codes.
// ----------------------------------------------------------------------------
package mts_pkg;

	// Word and register widths, default depth and reset capacity
	localparam int WORD_W      = 32;
	localparam int CAP_W       = 9;
	localparam int DEPTH_DEF   = 256;
	localparam int CAP_RESET   = 256;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	// Operation codes carried in the func field
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	// Register index of the capacity register
	localparam logic REG_CAPACITY = 1'b0;

	// Value reported for an empty stack or a failed pop
	localparam logic signed [WORD_W-1:0] NEG_ONE = -32'sd1;

	// Input request
	typedef struct packed {
		logic                     func;
		logic signed [WORD_W-1:0] value;
	} req_t;

	// Result
	typedef struct packed {
		logic signed [WORD_W-1:0] popped_value;
		logic signed [WORD_W-1:0] min_value;
		logic                     is_empty;
		logic                     is_full;
		logic                     error;
	} result_t;

	// One stack entry: the word and the running minimum at its depth
	typedef struct packed {
		logic signed [WORD_W-1:0] val;
		logic signed [WORD_W-1:0] min;
	} entry_t;

	// Control states
	typedef enum logic {
		ST_IDLE,
		ST_FILL
	} state_t;

endpackage

// File: rtl/core/mts_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_store
// Entry storage of the stack: one memory for the words and one for the
// running minimum, sharing a write port and a registered read port.
// ----------------------------------------------------------------------------
module mts_store #(
	parameter int DEPTH = mts_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  mts_pkg::entry_t      wdata,
	input  logic [AW-1:0]        raddr,
	output mts_pkg::entry_t      rdata
);

	logic signed [mts_pkg::WORD_W-1:0] val_mem [DEPTH];
	logic signed [mts_pkg::WORD_W-1:0] min_mem [DEPTH];

	// Write both memories at the same entry
	always_ff @(posedge clk) begin
		if (we) begin
			val_mem[waddr] <= wdata.val;
			min_mem[waddr] <= wdata.min;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rdata.val <= val_mem[raddr];
		rdata.min <= min_mem[raddr];
	end

endmodule

// File: rtl/core/min_tracking_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack
// LIFO stack of signed 32-bit words that reports the running minimum.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with in_data (func: push or pop,
//   value). Each request gives one result on out_valid/out_ready with
//   out_data (popped word, current minimum, empty, full, error).
//   The top entry and its minimum sit in registers; all entries also live
//   in two memories with a registered read.
//   A result is valid in the cycle after its request is accepted, except
//   that a pop from a depth of two or more needs a memory read to refill
//   the top registers: the request moves into the refill state with the
//   memory read registered, and the result is registered from there.
//   Requests are taken at one per cycle for pushes and for pops from a
//   depth of one or zero while the receiver takes results; a deeper pop
//   holds off new requests until the refill of the top registers is done.
//   The capacity register (APB, address 0) sets where the stack reports
//   full; values above DEPTH act as DEPTH. Write it only while idle.
//   Reset empties the stack and sets capacity to 256; memories are not
//   cleared. A stalled receiver holds the result register, and a new
//   request is taken only when that register is free or being emptied.
// ----------------------------------------------------------------------------
module min_tracking_stack #(
	parameter int DEPTH = mts_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  mts_pkg::req_t                   in_data,
	// result channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output mts_pkg::result_t                out_data,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mts_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [mts_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [mts_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > mts_pkg::CAP_W) ? CW : mts_pkg::CAP_W;

	// Registers
	mts_pkg::state_t                    state_q, state_d;
	logic [CW-1:0]                      count_q, count_d;
	logic signed [mts_pkg::WORD_W-1:0]  top_val_q, top_val_d;
	logic signed [mts_pkg::WORD_W-1:0]  top_min_q, top_min_d;
	logic signed [mts_pkg::WORD_W-1:0]  pend_val_q;
	logic [mts_pkg::CAP_W-1:0]          cap_q;
	logic                               out_valid_q;
	mts_pkg::result_t                   out_q;

	// Memory port signals
	logic                               mem_we;
	logic [AW-1:0]                      mem_waddr;
	logic [AW-1:0]                      mem_raddr;
	mts_pkg::entry_t                    mem_wdata;
	mts_pkg::entry_t                    mem_rdata;

	// Control
	logic                               in_fire;
	logic                               load_out;
	mts_pkg::result_t                   res_d;
	logic [CMPW-1:0]                    cap_ext;
	logic [CMPW-1:0]                    eff_cap;
	logic [CMPW-1:0]                    count_ext;
	logic [CMPW-1:0]                    count_inc_ext;
	logic                               cap_wr;

	mts_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Configuration port
	assign pready = 1'b1;
	assign cap_wr = psel && penable && pwrite && pready
		&& (paddr[mts_pkg::APB_ADDR_W-1:2] == mts_pkg::REG_CAPACITY);

	always_comb begin
		prdata = '0;
		if (paddr[mts_pkg::APB_ADDR_W-1:2] == mts_pkg::REG_CAPACITY) begin
			prdata[mts_pkg::CAP_W-1:0] = cap_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= mts_pkg::CAP_W'(mts_pkg::CAP_RESET);
		end else if (cap_wr) begin
			cap_q <= pwdata[mts_pkg::CAP_W-1:0];
		end
	end

	// Saturate capacity at the memory depth
	assign cap_ext       = CMPW'(cap_q);
	assign eff_cap       = (cap_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_ext;
	assign count_ext     = CMPW'(count_q);
	assign count_inc_ext = CMPW'(count_q) + CMPW'(1);

	// Handshake
	assign in_ready  = (state_q == mts_pkg::ST_IDLE) && (!out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Next state, memory access and result
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		top_val_d = top_val_q;
		top_min_d = top_min_q;
		load_out  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_raddr = AW'(count_q - CW'(2));
		mem_wdata.val = in_data.value;
		mem_wdata.min = in_data.value;
		res_d.popped_value = '0;
		res_d.min_value    = mts_pkg::NEG_ONE;
		res_d.is_empty     = (count_q == '0);
		res_d.is_full      = (count_ext >= eff_cap);
		res_d.error        = 1'b0;

		case (state_q)
			mts_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (in_data.func == mts_pkg::FUNC_PUSH) begin
						load_out = 1'b1;
						if (count_ext >= eff_cap) begin
							// drop the push, report the current minimum
							res_d.error = 1'b1;
							if (count_q != '0) begin
								res_d.min_value = top_min_q;
							end
						end else begin
							// store the word and its running minimum
							if ((count_q != '0) && !(in_data.value < top_min_q)) begin
								mem_wdata.min = top_min_q;
							end
							mem_we          = 1'b1;
							top_val_d       = in_data.value;
							top_min_d       = mem_wdata.min;
							count_d         = count_q + CW'(1);
							res_d.min_value = mem_wdata.min;
							res_d.is_empty  = 1'b0;
							res_d.is_full   = (count_inc_ext >= eff_cap);
						end
					end else begin
						if (count_q == '0) begin
							// pop on empty
							load_out           = 1'b1;
							res_d.popped_value = mts_pkg::NEG_ONE;
							res_d.error        = 1'b1;
						end else if (count_q == CW'(1)) begin
							// last entry leaves
							load_out           = 1'b1;
							count_d            = '0;
							res_d.popped_value = top_val_q;
							res_d.is_empty     = 1'b1;
							res_d.is_full      = (eff_cap == '0);
						end else begin
							// fetch the entry below the top
							count_d = count_q - CW'(1);
							state_d = mts_pkg::ST_FILL;
						end
					end
				end
			end
			mts_pkg::ST_FILL: begin
				// refill the top registers from memory
				load_out           = 1'b1;
				top_val_d          = mem_rdata.val;
				top_min_d          = mem_rdata.min;
				res_d.popped_value = pend_val_q;
				res_d.min_value    = mem_rdata.min;
				res_d.is_empty     = 1'b0;
				state_d            = mts_pkg::ST_IDLE;
			end
			default: begin
				state_d = mts_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mts_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		top_val_q <= top_val_d;
		top_min_q <= top_min_d;
		if (in_fire) begin
			pend_val_q <= top_val_q;
		end
		if (load_out) begin
			out_q <= res_d;
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(count_q) <= CMPW'(DEPTH))
		else $error("entry count exceeds depth");

	a_fill_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mts_pkg::ST_FILL) |-> !out_valid_q)
		else $error("result register busy during refill");

	a_deep_pop_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (in_data.func == mts_pkg::FUNC_POP) && (count_q > CW'(1)))
		|=> (state_q == mts_pkg::ST_FILL))
		else $error("deep pop did not start a refill");

	a_empty_min: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.is_empty) |-> (out_q.min_value == mts_pkg::NEG_ONE))
		else $error("empty result carries a minimum");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (in_data.func == mts_pkg::FUNC_PUSH)) |=> out_valid_q)
		else $error("push gave no result");
`endif

endmodule

// File: verif/min_tracking_stack_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_tb
// Drives push and pop requests into the minimum-tracking stack through a
// short table of directed steps, then through random phases at several
// capacity settings. A behavioral stack copy predicts results not given by
// hand; each is checked field by field in order under random gaps and stalls.
// ----------------------------------------------------------------------------
module min_tracking_stack_tb;

	localparam int STACK_DEPTH = mts_pkg::DEPTH_DEF;
	localparam int PLAN_ROWS   = 27;
	localparam int PHASES      = 12;

	typedef enum logic {
		ROW_CFG,
		ROW_REQ
	} row_kind_t;

	// One directed step: a capacity write or a request, with an optional
	// hand-written expectation
	typedef struct {
		row_kind_t   kind;
		logic        func;
		logic [31:0] arg;
		bit          typed;
		logic [31:0] pv;
		logic [31:0] mv;
		bit          em;
		bit          fu;
		bit          er;
	} step_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	mts_pkg::req_t                  in_data;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	mts_pkg::result_t               out_data;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [mts_pkg::APB_ADDR_W-1:0] paddr;
	logic [mts_pkg::APB_DATA_W-1:0] pwdata;
	logic [mts_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;

	// Shadow stack and its settings
	logic signed [mts_pkg::WORD_W-1:0] word_mem [STACK_DEPTH];
	logic signed [mts_pkg::WORD_W-1:0] floor_mem [STACK_DEPTH];
	int                                stack_depth;
	int                                cap_reg;

	mts_pkg::result_t results_due [$];
	int               fault_count = 0;
	bit               calm;
	int               stall_left = 0;

	step_row_t plan [PLAN_ROWS] = '{
		'{ROW_REQ, mts_pkg::FUNC_POP, 32'h0, 1, mts_pkg::NEG_ONE, mts_pkg::NEG_ONE, 1, 0, 1},
		'{ROW_REQ, mts_pkg::FUNC_PUSH, 32'h7FFFFFFF, 1, 32'h0, 32'h7FFFFFFF, 0, 0, 0},
		'{ROW_REQ, mts_pkg::FUNC_PUSH, 32'h80000000, 1, 32'h0, 32'h80000000, 0, 0, 0},
		'{ROW_REQ, mts_pkg::FUNC_PUSH, 32'h0,        1, 32'h0, 32'h80000000, 0, 0, 0},
		'{ROW_REQ, mts_pkg::FUNC_PUSH, 32'h80000000, 0, 32'h0, 32'h0,        0, 0, 0},
		'{ROW_REQ, mts_pkg::FUNC_POP,  32'h0,        0, 32'h0, 32'h0,        0, 0, 0},
		'{ROW_REQ, mts_pkg::FUNC_POP,  32'hFFFFFFFF, 0, 32'h0, 32'h0,        0, 0, 0},
		'{ROW_REQ, mts_pkg::FUNC_POP,  32'h0,        0, 32'h0, 32'h0,        0, 0, 0},
		'{ROW_REQ, mts_pkg::FUNC_POP,  32'h0,        0, 32'h0, 32'h0,        0, 0, 0},
		'{ROW_REQ, mts_pkg::FUNC_POP, 32'h0, 1, mts_pkg::NEG_ONE, mts_pkg::NEG_ONE, 1, 0, 1},
		'{ROW_CFG, mts_pkg::FUNC_PUSH, 32'd1,        0, 32'h0, 32'h0,        0, 0, 0},
		'{ROW_REQ, mts_pkg::FUNC_PUSH, 32'hFFFFFFFB, 1, 32'h0, 32'hFFFFFFFB, 0, 1, 0},
		'{ROW_REQ, mts_pkg::FUNC_PUSH, 32'd9,        1, 32'h0, 32'hFFFFFFFB, 0, 1, 1},
		'{ROW_REQ, mts_pkg::FUNC_POP, 32'h0, 1, 32'hFFFFFFFB, mts_pkg::NEG_ONE, 1, 0, 0},
		'{ROW_CFG, mts_pkg::FUNC_PUSH, 32'd0,        0, 32'h0, 32'h0,        0, 0, 0},
		'{ROW_REQ, mts_pkg::FUNC_PUSH, 32'd3, 1, 32'h0, mts_pkg::NEG_ONE, 1, 1, 1},
		'{ROW_REQ, mts_pkg::FUNC_POP, 32'h0, 1, mts_pkg::NEG_ONE, mts_pkg::NEG_ONE, 1, 1, 1},
		'{ROW_CFG, mts_pkg::FUNC_PUSH, 32'd300,      0, 32'h0, 32'h0,        0, 0, 0},
		'{ROW_REQ, mts_pkg::FUNC_PUSH, 32'd12,       0, 32'h0, 32'h0,        0, 0, 0},
		'{ROW_REQ, mts_pkg::FUNC_PUSH, 32'd4,        0, 32'h0, 32'h0,        0, 0, 0},
		'{ROW_REQ, mts_pkg::FUNC_PUSH, 32'd8,        0, 32'h0, 32'h0,        0, 0, 0},
		'{ROW_CFG, mts_pkg::FUNC_PUSH, 32'd2,        0, 32'h0, 32'h0,        0, 0, 0},
		'{ROW_REQ, mts_pkg::FUNC_PUSH, 32'd1,        1, 32'h0, 32'd4,        0, 1, 1},
		'{ROW_REQ, mts_pkg::FUNC_POP,  32'h0,        0, 32'h0, 32'h0,        0, 0, 0},
		'{ROW_REQ, mts_pkg::FUNC_POP,  32'h0,        0, 32'h0, 32'h0,        0, 0, 0},
		'{ROW_REQ, mts_pkg::FUNC_PUSH, 32'hFFFFFFFF, 0, 32'h0, 32'h0,        0, 0, 0},
		'{ROW_CFG, mts_pkg::FUNC_PUSH, 32'd256,      0, 32'h0, 32'h0,        0, 0, 0}
	};

	int caps [PHASES] = '{256, 1, 5, 300, 0, 17, 511, 2, 256, 3, 0, 9};

	min_tracking_stack dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("min_tracking_stack_tb: errors");
		$finish;
	end

	// Capacity in force: values above the depth act as the depth
	function automatic int capacity_limit();
		return (cap_reg > STACK_DEPTH) ? STACK_DEPTH : cap_reg;
	endfunction

	// Apply one request to the shadow stack and return its result
	function automatic mts_pkg::result_t apply_stack_op(mts_pkg::req_t r);
		mts_pkg::result_t res;
		int               lim;
		lim = capacity_limit();
		res.popped_value = '0;
		res.error        = 1'b0;
		if (r.func == mts_pkg::FUNC_PUSH) begin
			if (stack_depth >= lim) begin
				res.error = 1'b1;
			end else begin
				word_mem[stack_depth] = r.value;
				if (stack_depth > 0 && floor_mem[stack_depth-1] <= r.value)
					floor_mem[stack_depth] = floor_mem[stack_depth-1];
				else
					floor_mem[stack_depth] = r.value;
				stack_depth++;
			end
		end else if (stack_depth == 0) begin
			res.popped_value = mts_pkg::NEG_ONE;
			res.error        = 1'b1;
		end else begin
			stack_depth--;
			res.popped_value = word_mem[stack_depth];
		end
		res.min_value = (stack_depth > 0) ? floor_mem[stack_depth-1] : mts_pkg::NEG_ONE;
		res.is_empty  = (stack_depth == 0);
		res.is_full   = (stack_depth >= lim);
		return res;
	endfunction

	// Gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(15, 30);
	endfunction

	// Word to push: extremes, a narrow band for ties, or anything
	function automatic logic signed [mts_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2, 3, 4: return $signed(32'($urandom_range(0, 16))) - 32'sd8;
			default: return $signed($urandom);
		endcase
	endfunction

	// Send one request; record its expectation at the accepting edge.
	// Enter and leave at a falling edge.
	task automatic put_req(mts_pkg::req_t r, bit typed, mts_pkg::result_t typed_res);
		int               gap;
		mts_pkg::result_t res;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do
			@(posedge clk);
		while (!in_ready);
		res = apply_stack_op(r);
		results_due.push_back(typed ? typed_res : res);
		@(negedge clk);
	endtask

	// Write the capacity register once the stack has gone quiet
	task automatic write_capacity(logic [mts_pkg::CAP_W-1:0] cap);
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= mts_pkg::APB_ADDR_W'(4 * mts_pkg::REG_CAPACITY);
		pwdata  <= mts_pkg::APB_DATA_W'(cap);
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		cap_reg = cap;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Hold off the result channel at random
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (calm || $urandom_range(0, 3) != 0) begin
			out_ready <= 1'b1;
		end else begin
			out_ready  <= 1'b0;
			stall_left <= pick_gap();
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			fault_count++;
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
		end
	endtask

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		mts_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				fault_count++;
				$display("%0t: result with none expected, got %h", $time, out_data);
			end else begin
				want = results_due.pop_front();
				check_field("popped_value", want.popped_value, out_data.popped_value);
				check_field("min_value", want.min_value, out_data.min_value);
				check_field("is_empty", 32'(want.is_empty), 32'(out_data.is_empty));
				check_field("is_full", 32'(want.is_full), 32'(out_data.is_full));
				check_field("error", 32'(want.error), 32'(out_data.error));
			end
		end
	end

	initial begin
		mts_pkg::req_t    r;
		mts_pkg::result_t want;
		int               n;
		int               base_pct;
		int               pct;
		bit               big;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		stack_depth = 0;
		cap_reg     = mts_pkg::CAP_RESET;
		calm        = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed steps
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				write_capacity(plan[i].arg[mts_pkg::CAP_W-1:0]);
			end else begin
				r.func              = plan[i].func;
				r.value             = plan[i].arg;
				want.popped_value   = plan[i].pv;
				want.min_value      = plan[i].mv;
				want.is_empty       = plan[i].em;
				want.is_full        = plan[i].fu;
				want.error          = plan[i].er;
				put_req(r, plan[i].typed, want);
			end
		end

		// Random phases: large capacities fill up then drain a little,
		// small ones mix; a stack above its capacity is mostly popped
		caps[10] = $urandom_range(1, 256);
		for (int ph = 0; ph < PHASES; ph++) begin
			write_capacity(caps[ph][mts_pkg::CAP_W-1:0]);
			calm     = (ph % 3 == 1);
			big      = (capacity_limit() >= STACK_DEPTH);
			n        = big ? 360 : 70;
			base_pct = $urandom_range(30, 70);
			for (int k = 0; k < n; k++) begin
				pct = big ? ((k < 300) ? 95 : 20) : base_pct;
				if (stack_depth > capacity_limit())
					pct = 25;
				r.func  = ($urandom_range(0, 99) < pct) ? mts_pkg::FUNC_PUSH
					: mts_pkg::FUNC_POP;
				r.value = pick_word();
				put_req(r, 1'b0, '0);
			end
		end

		// Drain and let the block settle
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (fault_count == 0)
			$display("min_tracking_stack_tb: clean");
		else
			$display("min_tracking_stack_tb: errors");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/mts_pkg.sv
rtl/core/mts_store.sv
rtl/core/min_tracking_stack.sv
verif/min_tracking_stack_tb.sv
